FILE: sv/dxt_block_decoder_defines.svh
// assertion macros for the dxt block decoder rtl
`ifndef DXT_BLOCK_DECODER_DEFINES_SVH
`define DXT_BLOCK_DECODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define DXT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dxt_block_decoder: same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define DXT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dxt_block_decoder: next-cycle check failed");

`endif

FILE: sv/dxt_pkg.sv
// shared types, constants and helper functions for the dxt block decoder
`default_nettype none

package dxt_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PIX_COUNT   = 16;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0]  ALPHA_CLEAR  = 8'd0;

  typedef enum logic [1:0] {
    REG_FORMAT_DXT5   = 2'd0,
    REG_SWAP_RED_BLUE = 2'd1
  } reg_idx_t;

  // [2] red, [1] green, [0] blue
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic [15:0] color_end0;
    logic [15:0] color_end1;
    logic [31:0] color_codes;
    logic [7:0]  alpha_end0;
    logic [7:0]  alpha_end1;
    logic [47:0] alpha_codes;
  } block_t;

  typedef struct packed {
    logic            dxt5;
    rgb_t [3:0]      pal;
    logic [7:0][7:0] apal;
    logic [31:0]     color_codes;
    logic [47:0]     alpha_codes;
  } palette_t;

  // rgb565 to 8 bits per channel by bit replication
  function automatic rgb_t widen565(input logic [15:0] c, input logic swap);
    rgb_t w;
    w[2] = {c[15:11], c[15:13]};
    w[1] = {c[10:5], c[10:9]};
    w[0] = {c[4:0], c[4:2]};
    if (swap) begin
      w = {w[0], w[1], w[2]};
    end
    return w;
  endfunction

  // exact floor(x/3) for x below 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // exact floor(x/7) for x up to 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd2341;
    return p[21:14];
  endfunction

  // exact floor(x/5) for x up to 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd1639;
    return p[20:13];
  endfunction

endpackage

`default_nettype wire

FILE: sv/dxt_front.sv
// front end: takes a compressed block and builds its colour and alpha palettes
`default_nettype none

module dxt_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fmt_dxt5,
  input  wire logic             swap_rb,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire dxt_pkg::block_t  in_blk,
  output logic                  q_push,
  input  wire logic             q_full,
  output dxt_pkg::palette_t     q_data
);
  import dxt_pkg::*;

  logic   held;
  logic   held_next;
  block_t blk;
  logic   accept;
  rgb_t   e0;
  rgb_t   e1;
  logic   ends_equal;
  logic   four_colour;
  logic   alpha_gt;
  logic [8:0] mid;

  assign in_full = held && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = held && !q_full;

  always_comb begin
    held_next = held;
    if (accept) begin
      held_next = 1'b1;
    end else if (q_push) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk <= in_blk;
    end
  end

  always_comb begin
    e0          = widen565(blk.color_end0, swap_rb);
    e1          = widen565(blk.color_end1, swap_rb);
    ends_equal  = blk.color_end0 == blk.color_end1;
    four_colour = fmt_dxt5 || (blk.color_end0 > blk.color_end1);
    alpha_gt    = blk.alpha_end0 > blk.alpha_end1;
    mid         = '0;

    q_data             = '0;
    q_data.dxt5        = fmt_dxt5;
    q_data.color_codes = blk.color_codes;
    q_data.alpha_codes = blk.alpha_codes;
    q_data.pal[0]      = e0;
    q_data.pal[1]      = e1;

    for (int ch = 0; ch < 3; ch++) begin
      mid = 9'(e0[ch]) + 9'(e1[ch]);
      if (ends_equal) begin
        q_data.pal[2][ch] = e1[ch];
        q_data.pal[3][ch] = e1[ch];
      end else if (four_colour) begin
        q_data.pal[2][ch] = div3(10'({e0[ch], 1'b0}) + 10'(e1[ch]));
        q_data.pal[3][ch] = div3(10'(e0[ch]) + 10'({e1[ch], 1'b0}));
      end else begin
        // three-colour mode: midpoint and black
        q_data.pal[2][ch] = mid[8:1];
        q_data.pal[3][ch] = 8'd0;
      end
    end

    q_data.apal[0] = blk.alpha_end0;
    q_data.apal[1] = blk.alpha_end1;
    for (int k = 1; k <= 6; k++) begin
      if (alpha_gt) begin
        q_data.apal[k+1] = div7(11'(7 - k) * 11'(blk.alpha_end0)
                              + 11'(k) * 11'(blk.alpha_end1));
      end else if (k <= 4) begin
        q_data.apal[k+1] = div5(11'(5 - k) * 11'(blk.alpha_end0)
                              + 11'(k) * 11'(blk.alpha_end1));
      end else if (k == 5) begin
        q_data.apal[k+1] = ALPHA_CLEAR;
      end else begin
        q_data.apal[k+1] = ALPHA_OPAQUE;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/dxt_fifo.sv
// short queue of decoded palettes between the front and back ends
`default_nettype none

module dxt_fifo #(
  parameter int unsigned DEPTH = dxt_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire dxt_pkg::palette_t din,
  input  wire logic              pop,
  output logic                   empty,
  output dxt_pkg::palette_t      dout
);
  import dxt_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  palette_t       entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic [PW-1:0]  wr_ptr_next;
  logic [PW-1:0]  rd_ptr_next;
  logic [CW-1:0]  count_next;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign dout  = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dxt_back.sv
// back end: walks the sixteen pixels of the head palette into the output register
`default_nettype none

module dxt_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire dxt_pkg::palette_t q_data,
  output logic                   q_pop,
  input  wire logic              out_pop,
  output logic                   out_empty,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue,
  output logic [7:0]             alpha_out,
  output logic [3:0]             pixel_number,
  output logic                   last_pixel
);
  import dxt_pkg::*;

  localparam logic [3:0] LAST_PIX = 4'(PIX_COUNT - 1);

  logic       out_valid;
  logic       out_valid_next;
  logic [3:0] cnt;
  logic       step;
  logic [1:0] ci;
  logic [2:0] ai;
  rgb_t       colour;
  logic [7:0] alpha;

  assign out_empty = !out_valid;
  // step when a palette is queued and the output register is free or being drained this cycle
  assign step  = !q_empty && (!out_valid || out_pop);
  assign q_pop = step && (cnt == LAST_PIX);

  always_comb begin
    ci     = q_data.color_codes[{cnt, 1'b0} +: 2];
    ai     = q_data.alpha_codes[(6'({cnt, 1'b0}) + 6'(cnt)) +: 3];
    colour = q_data.pal[ci];
    alpha  = q_data.dxt5 ? q_data.apal[ai] : ALPHA_OPAQUE;
    out_valid_next = out_valid;
    if (step) begin
      out_valid_next = 1'b1;
    end else if (out_pop) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      out_valid <= out_valid_next;
      if (step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      red          <= colour[2];
      green        <= colour[1];
      blue         <= colour[0];
      alpha_out    <= alpha;
      pixel_number <= cnt;
      last_pixel   <= cnt == LAST_PIX;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dxt_block_decoder.sv
// top level of the dxt1/dxt5 block decoder
//
// Input side is a queue: a compressed 4x4 block is taken at a clock edge with
// push high and full low. Output side is a queue too: while empty is low the
// oldest pixel sits on red/green/blue/alpha_out/pixel_number/last_pixel, and
// a transaction completes at an edge with pop high and empty low.
// Each block yields sixteen pixels in raster order, last_pixel marks the
// sixteenth. The first pixel passes the front input register and palette queue
// to the output register. Throughput is one pixel per cycle, set by the back
// end, while pop keeps up and a palette is queued. The front end builds the
// palettes combinationally from its input register into a two-entry queue, so
// up to two blocks wait behind the one being emitted. A stalled receiver holds
// the output register; the front keeps taking blocks until its register and
// the queue are all occupied. Configuration (format_dxt5, swap_red_blue) must
// be written by the user via cfg_write, cfg_index and cfg_data only while the
// block is idle (not enforced). Unknown indexes are ignored. Synchronous reset
// clears both registers and empties the pipeline.
`default_nettype none

`include "dxt_block_decoder_defines.svh"

module dxt_block_decoder #(
  parameter int unsigned QDEPTH = dxt_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] color_end0,
  input  wire logic [15:0] color_end1,
  input  wire logic [31:0] color_codes,
  input  wire logic [7:0]  alpha_end0,
  input  wire logic [7:0]  alpha_end1,
  input  wire logic [47:0] alpha_codes,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha_out,
  output logic [3:0]       pixel_number,
  output logic             last_pixel
);
  import dxt_pkg::*;

  logic     fmt_dxt5;
  logic     swap_rb;
  block_t   in_blk;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  palette_t q_din;
  palette_t q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_dxt5 <= 1'b0;
      swap_rb  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FORMAT_DXT5:   fmt_dxt5 <= cfg_data;
        REG_SWAP_RED_BLUE: swap_rb  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_blk.color_end0  = color_end0;
    in_blk.color_end1  = color_end1;
    in_blk.color_codes = color_codes;
    in_blk.alpha_end0  = alpha_end0;
    in_blk.alpha_end1  = alpha_end1;
    in_blk.alpha_codes = alpha_codes;
  end

  dxt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .fmt_dxt5 (fmt_dxt5),
    .swap_rb  (swap_rb),
    .in_push  (push),
    .in_full  (full),
    .in_blk   (in_blk),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_data   (q_din)
  );

  dxt_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .din   (q_din),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout)
  );

  dxt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_dout),
    .q_pop        (q_pop),
    .out_pop      (pop),
    .out_empty    (empty),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha_out    (alpha_out),
    .pixel_number (pixel_number),
    .last_pixel   (last_pixel)
  );

  // last_pixel flags exactly the final raster position
  `DXT_ASSERT_SAME(a_last_matches_number, !empty, last_pixel == (pixel_number == 4'd15))

  // within a block the next pixel follows straight on with the next number
  `DXT_ASSERT_NEXT(a_pixels_in_order, !rst && pop && !empty && !last_pixel, !empty && (pixel_number == $past(pixel_number) + 4'd1))

  // the palette queue is only read from when the back end has a block
  `DXT_ASSERT_SAME(a_pop_needs_entry, q_pop, !q_empty)

endmodule

`default_nettype wire
